// ===== sv/udc_pkg.sv =====
package udc_pkg;

    // day number of 1970-01-01 when days are counted from March 1 of year 0
    localparam longint unsigned EpochDay = 64'd719468;
    localparam longint unsigned SecsPerDay = 64'd86400;
    localparam longint unsigned MaxSeconds = 64'd253402300799;
    localparam int unsigned YearMin = 1970;
    localparam int unsigned YearMax = 9999;

    // year guess is (10000 * d + 14780) / 3652425
    localparam longint unsigned YearScale = 64'd10000;
    localparam longint unsigned YearBias = 64'd14780;
    localparam longint unsigned YearDiv = 64'd3652425;
    // offset of the scaled guess numerator when counting from the epoch
    localparam longint unsigned YearNumOffset = YearScale * EpochDay + YearBias;

    // months of the March based year, March is month 0
    localparam int unsigned MonthsPerYear = 12;
    localparam logic [3:0] FirstMonthNextYear = 4'd10;

    // days before a month of the March based year, (306 * m + 5) / 10
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd0:  d = 9'd0;
            4'd1:  d = 9'd31;
            4'd2:  d = 9'd61;
            4'd3:  d = 9'd92;
            4'd4:  d = 9'd122;
            4'd5:  d = 9'd153;
            4'd6:  d = 9'd184;
            4'd7:  d = 9'd214;
            4'd8:  d = 9'd245;
            4'd9:  d = 9'd275;
            4'd10: d = 9'd306;
            4'd11: d = 9'd337;
            4'd12: d = 9'd367;
            4'd13: d = 9'd398;
            4'd14: d = 9'd428;
            4'd15: d = 9'd459;
        endcase
        return d;
    endfunction

    // calendar month to March based month, (month + 9) mod 12
    function automatic logic [3:0] month_shift(input logic [3:0] month);
        logic [4:0] s;
        s = {1'b0, month} + 5'd9;
        if (s >= 5'(2 * MonthsPerYear))
        begin
            s = s - 5'(2 * MonthsPerYear);
        end
        else if (s >= 5'(MonthsPerYear))
        begin
            s = s - 5'(MonthsPerYear);
        end
        return s[3:0];
    endfunction

endpackage

// ===== sv/udc_in_if.sv =====
interface udc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [37:0] seconds_in;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;

    modport source (
        output valid, action, seconds_in, year_in, month_in, day_in,
               hour_in, minute_in, second_in,
        input  ready
    );

    modport sink (
        input  valid, action, seconds_in, year_in, month_in, day_in,
               hour_in, minute_in, second_in,
        output ready
    );
endinterface

// ===== sv/udc_out_if.sv =====
interface udc_out_if;
    logic        valid;
    logic        ready;
    logic [37:0] seconds_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic        range_error;

    modport source (
        output valid, seconds_out, year_out, month_out, day_out, hour_out,
               minute_out, second_out, range_error,
        input  ready
    );

    modport sink (
        input  valid, seconds_out, year_out, month_out, day_out, hour_out,
               minute_out, second_out, range_error,
        output ready
    );
endinterface

// ===== sv/unix_seconds_date_converter.sv =====
// Unix seconds <-> Gregorian date converter
//
// in_ch carries one conversion per transfer: action 0 turns seconds_in into
// a date and time of day, action 1 turns the date fields into seconds.
// out_ch carries one result per accepted item, in order. Fields that do not
// belong to the chosen direction read 0; range_error flags results outside
// years 1970 to 9999 (seconds_out is then 0).
//
// The pipeline takes one item per cycle unless out_ch stalls; its depth is
// set by the chain of constant dividers (seconds/86400, year guess, year/100)
// each taking two stages. All stages advance together when the output
// register is empty or taken, so a stalled receiver holds every stage and
// in_ch.ready drops; nothing is lost or repeated. Reset clears only the
// valid bits, after which the block accepts immediately.
module unix_seconds_date_converter (
    input  logic             clk,
    input  logic             rst_n,
    udc_in_if.sink           in_ch,
    udc_out_if.source        out_ch
);

    localparam int NS = 12;

    typedef struct packed {
        logic               act;
        logic [37:0]        secs;
        logic [14:0]        y;
        logic [3:0]         m;
        logic               e1;
        logic [4:0]         day;
        logic [16:0]        t;
        logic [21:0]        d;
        logic [16:0]        tod;
        logic [35:0]        x;
        logic [4:0]         hour;
        logic [11:0]        rem3600;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [23:0]        dby;
        logic               leap;
        logic [8:0]         doy;
        logic signed [24:0] days1;
        logic [3:0]         mi;
        logic signed [41:0] secs1;
    } stage_t;

    stage_t        stg_reg  [1:NS];
    stage_t        stg_next [1:NS];
    logic [NS:1]   v_reg;
    logic          vo_reg;
    logic          en;

    logic [21:0]   q675;
    logic [9:0]    r675;
    logic [14:0]   qyear;
    logic [5:0]    q3600;
    logic [11:0]   r3600;
    logic [8:0]    q100;
    logic [6:0]    r100;
    logic [5:0]    q60;
    logic [5:0]    r60;

    logic [3:0]         m_shift;
    logic               wrap;
    logic signed [24:0] diff;
    logic signed [24:0] days1_c;
    logic [3:0]         mi_cnt;
    logic [14:0]        year_c;
    logic [3:0]         month_c;
    logic [8:0]         day_c;
    logic               err1;

    logic [37:0] seconds_next, seconds_reg;
    logic [13:0] year_next, year_reg;
    logic [3:0]  month_next, month_reg;
    logic [4:0]  day_next, day_reg;
    logic [4:0]  hour_next, hour_reg;
    logic [5:0]  minute_next, minute_reg;
    logic [5:0]  second_next, second_reg;
    logic        range_next, range_reg;

    // whole pipeline moves unless the output holds an untaken result
    assign en          = !vo_reg || out_ch.ready;
    assign in_ch.ready = en;

    // constant dividers
    udc_cdiv #(.NW(31), .D(675), .QW(22), .RW(10)) u_div_day (
        .clk(clk), .en(en), .num(stg_reg[1].secs[37:7]), .quo(q675), .rem(r675)
    );

    udc_cdiv #(.NW(36), .D(udc_pkg::YearDiv), .QW(15), .RW(22)) u_div_year (
        .clk(clk), .en(en), .num(stg_reg[4].x), .quo(qyear), .rem()
    );

    udc_cdiv #(.NW(17), .D(3600), .QW(6), .RW(12)) u_div_hour (
        .clk(clk), .en(en), .num(stg_reg[4].tod), .quo(q3600), .rem(r3600)
    );

    udc_cdiv #(.NW(15), .D(100), .QW(9), .RW(7)) u_div_cent (
        .clk(clk), .en(en), .num(stg_reg[7].y), .quo(q100), .rem(r100)
    );

    udc_cdiv #(.NW(12), .D(60), .QW(6), .RW(6)) u_div_min (
        .clk(clk), .en(en), .num(stg_reg[7].rem3600), .quo(q60), .rem(r60)
    );

    // stage logic
    always_comb
    begin
        m_shift = udc_pkg::month_shift(in_ch.month_in);
        wrap    = (m_shift >= udc_pkg::FirstMonthNextYear);

        // capture, March based month, year shift and time of day sum
        stg_next[1]        = '0;
        stg_next[1].act    = in_ch.action;
        stg_next[1].secs   = in_ch.seconds_in;
        stg_next[1].m      = m_shift;
        stg_next[1].e1     = wrap && (in_ch.year_in == 14'd0);
        stg_next[1].y      = (wrap && (in_ch.year_in != 14'd0))
                             ? {1'b0, in_ch.year_in} - 15'd1
                             : {1'b0, in_ch.year_in};
        stg_next[1].day    = in_ch.day_in;
        stg_next[1].t      = 17'(in_ch.hour_in) * 17'd3600
                             + 17'(in_ch.minute_in) * 17'd60
                             + 17'(in_ch.second_in);

        for (int k = 2; k <= NS; k++)
        begin
            stg_next[k] = stg_reg[k-1];
        end

        // day count and time of day, scaled year guess numerator
        stg_next[4].tod = {r675[9:0], stg_reg[3].secs[6:0]};
        stg_next[4].d   = 22'(q675 + 22'(udc_pkg::EpochDay));
        stg_next[4].x   = 36'(q675) * 36'(udc_pkg::YearScale)
                          + 36'(udc_pkg::YearNumOffset);

        // year guess and hours
        if (!stg_reg[6].act)
        begin
            stg_next[7].y = qyear;
        end
        stg_next[7].hour    = 5'(q3600);
        stg_next[7].rem3600 = r3600;

        // days before the year and leap flag of that year
        stg_next[10].dby    = 24'(stg_reg[9].y) * 24'd365
                              + 24'(stg_reg[9].y >> 2)
                              - 24'(q100)
                              + 24'(q100 >> 2);
        stg_next[10].leap   = (stg_reg[9].y[1:0] == 2'd0)
                              && ((r100 != 7'd0) || (q100[1:0] == 2'd0));
        stg_next[10].minute = q60;
        stg_next[10].second = r60;

        // day of year with the one year correction, or total days
        diff    = $signed({3'b0, stg_reg[10].d}) - $signed({1'b0, stg_reg[10].dby});
        days1_c = $signed({1'b0, stg_reg[10].dby})
                  + $signed(25'(udc_pkg::days_before_month(stg_reg[10].m)))
                  + $signed(25'(stg_reg[10].day))
                  - 25'sd1
                  - $signed(25'(udc_pkg::EpochDay));
        if (!stg_reg[10].act)
        begin
            if (diff < 0)
            begin
                stg_next[11].doy = 9'(diff + 25'sd365 + 25'(stg_reg[10].leap));
                stg_next[11].y   = stg_reg[10].y - 15'd1;
            end
            else
            begin
                stg_next[11].doy = 9'(diff);
            end
        end
        else
        begin
            stg_next[11].days1 = days1_c;
        end

        // month of the March based year, or seconds total
        mi_cnt = '0;
        for (int k = 1; k < udc_pkg::MonthsPerYear; k++)
        begin
            if (stg_reg[11].doy >= udc_pkg::days_before_month(4'(k)))
            begin
                mi_cnt = mi_cnt + 4'd1;
            end
        end
        stg_next[12].mi    = mi_cnt;
        stg_next[12].secs1 = 42'(stg_reg[11].days1) * 42'sd86400
                             + $signed(42'(stg_reg[11].t));
    end

    // result formatting
    always_comb
    begin
        year_c  = stg_reg[NS].y
                  + 15'(stg_reg[NS].mi >= udc_pkg::FirstMonthNextYear);
        month_c = (stg_reg[NS].mi >= udc_pkg::FirstMonthNextYear)
                  ? stg_reg[NS].mi - 4'd9
                  : stg_reg[NS].mi + 4'd3;
        day_c   = stg_reg[NS].doy - udc_pkg::days_before_month(stg_reg[NS].mi) + 9'd1;
        err1    = stg_reg[NS].e1 || (stg_reg[NS].secs1 < 0)
                  || (stg_reg[NS].secs1 > $signed(42'(udc_pkg::MaxSeconds)));

        seconds_next = '0;
        year_next    = '0;
        month_next   = '0;
        day_next     = '0;
        hour_next    = '0;
        minute_next  = '0;
        second_next  = '0;
        if (!stg_reg[NS].act)
        begin
            year_next   = year_c[13:0];
            month_next  = month_c;
            day_next    = day_c[4:0];
            hour_next   = stg_reg[NS].hour;
            minute_next = stg_reg[NS].minute;
            second_next = stg_reg[NS].second;
            range_next  = (year_c < 15'(udc_pkg::YearMin))
                          || (year_c > 15'(udc_pkg::YearMax));
        end
        else
        begin
            seconds_next = err1 ? '0 : 38'(stg_reg[NS].secs1);
            range_next   = err1;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[NS-1:1], in_ch.valid};
            vo_reg <= v_reg[NS];
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg     <= stg_next;
            seconds_reg <= seconds_next;
            year_reg    <= year_next;
            month_reg   <= month_next;
            day_reg     <= day_next;
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
            second_reg  <= second_next;
            range_reg   <= range_next;
        end
    end

    assign out_ch.valid       = vo_reg;
    assign out_ch.seconds_out = seconds_reg;
    assign out_ch.year_out    = year_reg;
    assign out_ch.month_out   = month_reg;
    assign out_ch.day_out     = day_reg;
    assign out_ch.hour_out    = hour_reg;
    assign out_ch.minute_out  = minute_reg;
    assign out_ch.second_out  = second_reg;
    assign out_ch.range_error = range_reg;

endmodule

// ===== sv/udc_cdiv.sv =====
// two stage divider by a constant: reciprocal estimate, then one correction
module udc_cdiv #(
    parameter int              NW = 8,
    parameter longint unsigned D  = 3,
    parameter int              QW = 8,
    parameter int              RW = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    output logic [QW-1:0] quo,
    output logic [RW-1:0] rem
);

    // floor(2^NW / D) gives an estimate that is low by at most one
    localparam longint unsigned Recip = (64'd1 << NW) / D;
    localparam int MW = $clog2(Recip + 64'd1);
    localparam int PW = NW + MW;

    logic [PW-1:0] prod;
    logic [QW-1:0] q0_next;
    logic [QW-1:0] q0_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] r0;
    logic          ge;
    logic [QW-1:0] quo_next;
    logic [RW-1:0] rem_next;
    logic [QW-1:0] quo_reg;
    logic [RW-1:0] rem_reg;

    // estimate stage
    assign prod    = PW'(num) * PW'(Recip);
    assign q0_next = QW'(prod >> NW);

    // correction stage
    assign r0       = num_reg - NW'(q0_reg) * NW'(D);
    assign ge       = (r0 >= NW'(D));
    assign quo_next = q0_reg + QW'(ge);
    assign rem_next = ge ? RW'(r0 - NW'(D)) : RW'(r0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg  <= q0_next;
            num_reg <= num;
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quo = quo_reg;
    assign rem = rem_reg;

endmodule

// ===== bench/udc_date_checker.sv =====
module udc_date_checker (
    input  logic        clk,
    input  logic        rst_n,
    udc_in_if           in_ch,
    udc_out_if          out_ch,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          range_seen
);

    typedef struct packed {
        logic [37:0] seconds;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        range_error;
    } udc_result_t;

    udc_result_t expected_results[$];

    function automatic longint days_before_civil_year(input longint y);
        return 365 * y + y / 4 - y / 100 + y / 400;
    endfunction

    function automatic longint days_before_march_month(input longint m);
        return (m * 306 + 5) / 10;
    endfunction

    // civil date conversion in either direction
    function automatic udc_result_t convert_timestamp(
        input logic action, input logic [37:0] secs_in, input logic [13:0] yr,
        input logic [3:0] mon, input logic [4:0] dy, input logic [4:0] hr,
        input logic [5:0] mn, input logic [5:0] sc);
        udc_result_t r;
        longint secs, days, tod, d, y, doy, mi, year, m, total;
        r = '0;
        if (action == 1'b0)
        begin
            secs = longint'(secs_in);
            days = secs / 86400;
            tod = secs - days * 86400;
            d = days + longint'(udc_pkg::EpochDay);
            y = (10000 * d + 14780) / 3652425;
            doy = d - days_before_civil_year(y);
            if (doy < 0)
            begin
                y = y - 1;
                doy = d - days_before_civil_year(y);
            end
            mi = (100 * doy + 52) / 3060;
            year = y + (mi + 2) / 12;
            r.year = 14'(year);
            r.month = 4'((mi + 2) % 12 + 1);
            r.day = 5'(doy - days_before_march_month(mi) + 1);
            r.hour = 5'(tod / 3600);
            r.minute = 6'((tod % 3600) / 60);
            r.second = 6'(tod % 60);
            r.range_error = (year < longint'(udc_pkg::YearMin)
                             || year > longint'(udc_pkg::YearMax));
        end
        else
        begin
            m = (longint'(mon) + 9) % 12;
            y = longint'(yr) - m / 10;
            days = days_before_civil_year(y) + days_before_march_month(m)
                   + (longint'(dy) - 1) - longint'(udc_pkg::EpochDay);
            total = longint'(sc) + 60 * (longint'(mn) + 60 * (longint'(hr) + 24 * days));
            if (total < 0 || total > longint'(udc_pkg::MaxSeconds))
            begin
                r.range_error = 1'b1;
            end
            else
            begin
                r.seconds = 38'(total);
            end
        end
        return r;
    endfunction

    udc_result_t got;
    udc_result_t want;

    assign got = '{out_ch.seconds_out, out_ch.year_out, out_ch.month_out, out_ch.day_out,
                   out_ch.hour_out, out_ch.minute_out, out_ch.second_out,
                   out_ch.range_error};

    // predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
            results_seen <= 0;
            range_seen <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(convert_timestamp(in_ch.action,
                    in_ch.seconds_in, in_ch.year_in, in_ch.month_in, in_ch.day_in,
                    in_ch.hour_in, in_ch.minute_in, in_ch.second_in));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen <= results_seen + 1;
                if (got.range_error)
                begin
                    range_seen <= range_seen + 1;
                end
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected result transfer: %p", got);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("mismatch: expected %p", want);
                            $display("          actual   %p", got);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_results.size();
        end
    end
endmodule

// ===== bench/testbench.sv =====
module testbench;

    localparam int RandomItems = 1700;
    localparam int CalmItems = 200;
    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles = 40;
    localparam logic ToDate = 1'b0;
    localparam logic ToSeconds = 1'b1;

    logic clk;
    logic rst_n;
    logic calm;
    logic long_hold;
    int   fail_count;
    int   pending;
    int   results_seen;
    int   range_seen;
    int   idle_cycles;
    int   items_sent;

    udc_in_if  in_ch();
    udc_out_if out_ch();

    unix_seconds_date_converter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    udc_date_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .range_seen   (range_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // offer one item and hold it until the transfer, with random gaps before it
    task automatic send_item(input logic act, input logic [37:0] secs,
                             input logic [13:0] yr, input logic [3:0] mon,
                             input logic [4:0] dy, input logic [4:0] hr,
                             input logic [5:0] mn, input logic [5:0] sc);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.seconds_in <= secs;
        in_ch.year_in <= yr;
        in_ch.month_in <= mon;
        in_ch.day_in <= dy;
        in_ch.hour_in <= hr;
        in_ch.minute_in <= mn;
        in_ch.second_in <= sc;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_seconds(input logic [37:0] secs);
        send_item(ToDate, secs, 14'($urandom), 4'($urandom), 5'($urandom),
                  5'($urandom), 6'($urandom), 6'($urandom));
    endtask

    task automatic send_date(input logic [13:0] yr, input logic [3:0] mon,
                             input logic [4:0] dy, input logic [4:0] hr,
                             input logic [5:0] mn, input logic [5:0] sc);
        send_item(ToSeconds, 38'({$urandom, $urandom}), yr, mon, dy, hr, mn, sc);
    endtask

    // receiver: random stall bursts, one long hold-off, none near the end
    initial
    begin
        int stall;
        logic held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold && !held)
            begin
                out_ch.ready <= 1'b0;
                repeat (60) @(posedge clk);
                held = 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 19);
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("FAIL unix_seconds_date_converter");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int sel;
        calm = 1'b0;
        long_hold = 1'b0;
        items_sent = 0;
        in_ch.valid <= 1'b0;
        in_ch.action <= ToDate;
        in_ch.seconds_in <= '0;
        in_ch.year_in <= '0;
        in_ch.month_in <= '0;
        in_ch.day_in <= '0;
        in_ch.hour_in <= '0;
        in_ch.minute_in <= '0;
        in_ch.second_in <= '0;
        @(posedge rst_n);
        @(posedge clk);

        // directed: epoch, limits, leap days, odd months, overflows
        send_seconds(38'd0);
        send_seconds(38'd253402300799);
        send_seconds(38'd253402300800);
        send_seconds('1);
        send_seconds(38'd951782400);
        send_seconds(38'd951868799);
        send_seconds(38'd4107542399);
        send_date(14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
        send_date(14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        send_date(14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd60);
        send_date(14'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        send_date(14'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        send_date('1, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
        send_date(14'd2000, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0);
        send_date(14'd2100, 4'd2, 5'd31, 5'd0, 6'd0, 6'd0);
        send_date(14'd2024, 4'd0, 5'd15, 5'd1, 6'd2, 6'd3);
        send_date(14'd2024, 4'd13, 5'd15, 5'd1, 6'd2, 6'd3);
        send_date(14'd2024, 4'd14, 5'd29, 5'd1, 6'd2, 6'd3);
        send_date(14'd2024, 4'd15, 5'd1, 5'd1, 6'd2, 6'd3);
        send_date(14'd1970, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0);

        // long receiver hold-off while items keep coming
        long_hold = 1'b1;
        repeat (30) send_seconds(38'({$urandom, $urandom}));

        for (int i = 0; i < RandomItems; i++)
        begin
            if (i == RandomItems - CalmItems)
            begin
                calm = 1'b1;
            end
            sel = $urandom_range(0, 9);
            if (sel < 4)
            begin
                send_seconds(38'($urandom_range(0, 2147483647)) * 38'd118
                             + 38'($urandom_range(0, 117)));
            end
            else if (sel == 4)
            begin
                send_seconds(38'({$urandom, $urandom}));
            end
            else if (sel < 9)
            begin
                send_date(14'($urandom_range(1970, 9999)), 4'($urandom_range(1, 12)),
                          5'($urandom_range(1, 28)), 5'($urandom_range(0, 23)),
                          6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
            end
            else
            begin
                send_date(14'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                          6'($urandom), 6'($urandom));
            end
        end
        in_ch.valid <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        $display("sent %0d conversions both ways, checked %0d results, %0d out of range",
                 items_sent, results_seen, range_seen);
        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS unix_seconds_date_converter");
        end
        else
        begin
            $display("FAIL unix_seconds_date_converter");
        end
        $finish;
    end
endmodule

// ===== unix_seconds_date_converter.f =====
sv/udc_pkg.sv
sv/udc_in_if.sv
sv/udc_out_if.sv
sv/udc_cdiv.sv
sv/unix_seconds_date_converter.sv
bench/udc_date_checker.sv
bench/testbench.sv
